>>> rtl/core/free_page_stack_allocator_top_assert.svh
// Assertion macros shared by the free page stack allocator checkers
`ifndef FREE_PAGE_STACK_ALLOCATOR_TOP_ASSERT_SVH
`define FREE_PAGE_STACK_ALLOCATOR_TOP_ASSERT_SVH

// Clocked check, switched off while reset is held
`define FPSA_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset
`define FPSA_CHK_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/fpsa_pkg.sv
// Package: constants, codes and control types of the free page stack allocator
package fpsa_pkg;

  localparam int PAGE_BITS = 12;
  localparam int MAX_PAGES = 4096;

  localparam int ADDR_W  = 32;
  localparam int PN_W    = ADDR_W - PAGE_BITS;       // page number width
  localparam int IDX_W   = $clog2(MAX_PAGES);        // stack index width
  localparam int CNT_W   = $clog2(MAX_PAGES + 1);    // stack count width
  localparam int FIRST_W = ADDR_W + 1 - PAGE_BITS;   // rounded first page, no wrap
  localparam int FC_W    = 13;                       // free_count field width
  localparam int CFG_IDX_W = 1;

  localparam logic [1:0] KIND_FREE  = 2'd0;
  localparam logic [1:0] KIND_ALLOC = 2'd1;
  localparam logic [1:0] KIND_INIT  = 2'd2;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_EMPTY = 2'd1;
  localparam logic [1:0] STS_BAD   = 2'd2;
  localparam logic [1:0] STS_OVF   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_END   = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic start;      // input word accepted this cycle
    logic fill_step;  // write one init entry
    logic load_out;   // move the result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic init_req;   // the offered word is an init
    logic fill_done;  // no init entries left to write
    logic out_busy;   // output register full and not taken
  } dp_sts_t;

endpackage

>>> rtl/core/fpsa_ifs.sv
// Channel interfaces: request, result and configuration write
interface fpsa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [fpsa_pkg::ADDR_W-1:0] page_addr;
  modport source (output valid, kind, page_addr, input ready);
  modport sink   (input valid, kind, page_addr, output ready);
endinterface

interface fpsa_out_if;
  logic        valid;
  logic        ready;
  logic [fpsa_pkg::ADDR_W-1:0] alloc_addr;
  logic [1:0]  status;
  logic [fpsa_pkg::FC_W-1:0]   free_count;
  modport source (output valid, alloc_addr, status, free_count, input ready);
  modport sink   (input valid, alloc_addr, status, free_count, output ready);
endinterface

interface fpsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [fpsa_pkg::CFG_IDX_W-1:0] index;
  logic [fpsa_pkg::ADDR_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/fpsa_ram.sv
// Generic single-write, single-read RAM with registered read data
module fpsa_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/fpsa_ctrl.sv
// Controller state machine: accept, init fill sweep, result hand-off
module fpsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fpsa_pkg::dp_sts_t   sts,
  output fpsa_pkg::ctrl_cmd_t cmd
);

  fpsa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpsa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      fpsa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = sts.init_req ? fpsa_pkg::ST_FILL : fpsa_pkg::ST_RESP;
        end
      end
      fpsa_pkg::ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_done) begin
          state_nxt = fpsa_pkg::ST_RESP;
        end
      end
      fpsa_pkg::ST_RESP: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = fpsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fpsa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/fpsa_dp.sv
// Datapath: region registers, stack count, page stack RAM, result register
module fpsa_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   in_kind,
  input  logic [fpsa_pkg::ADDR_W-1:0]  in_page_addr,
  input  fpsa_pkg::ctrl_cmd_t          cmd,
  output fpsa_pkg::dp_sts_t            sts,
  fpsa_cfg_if.sink                     cfg_chan,
  fpsa_out_if.source                   out_chan
);

  localparam int PB = fpsa_pkg::PAGE_BITS;
  localparam int AW = fpsa_pkg::ADDR_W;
  localparam int CW = fpsa_pkg::CNT_W;
  localparam int IW = fpsa_pkg::IDX_W;
  localparam int PW = fpsa_pkg::PN_W;
  localparam int FW = fpsa_pkg::FIRST_W;

  logic [AW-1:0] region_start_r, region_end_r;
  logic [CW-1:0] count_r;
  logic [PW-1:0] fill_pg_r;
  logic [IW-1:0] fill_idx_r;
  logic [CW-1:0] fill_left_r;
  logic [1:0]    res_status_r;
  logic          res_use_ram_r;
  logic          out_valid_r;
  logic [AW-1:0] out_addr_r;
  logic [1:0]    out_status_r;
  logic [fpsa_pkg::FC_W-1:0] out_count_r;

  // init span
  logic [AW:0]   start_up;
  logic [FW-1:0] first_pg;
  logic [PW-1:0] limit_pg;
  logic [FW-1:0] n_raw;
  logic          n_sat;
  logic [CW-1:0] n_pages;

  // request decode
  logic          bad_free, full, empty;
  logic          push_ok, pop_ok;
  logic [CW-1:0] cnt_m1;
  logic [1:0]    new_status;

  // RAM ports
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [PW-1:0] ram_wdata, ram_rdata;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r <= '0;
      region_end_r   <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        fpsa_pkg::REG_REGION_START: region_start_r <= cfg_chan.data;
        fpsa_pkg::REG_REGION_END:   region_end_r   <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  assign start_up = {1'b0, region_start_r} + (AW+1)'((64'd1 << PB) - 64'd1);
  assign first_pg = start_up[AW:PB];
  assign limit_pg = region_end_r[AW-1:PB];
  assign n_raw    = ({1'b0, limit_pg} > first_pg) ? ({1'b0, limit_pg} - first_pg) : '0;
  assign n_sat    = 34'(n_raw) > 34'(fpsa_pkg::MAX_PAGES);
  assign n_pages  = n_sat ? CW'(fpsa_pkg::MAX_PAGES) : CW'(n_raw);

  assign bad_free = (in_page_addr[PB-1:0] != '0) || (in_page_addr < region_start_r) ||
                    (in_page_addr >= region_end_r);
  assign full     = count_r >= CW'(fpsa_pkg::MAX_PAGES);
  assign empty    = count_r == '0;
  assign cnt_m1   = count_r - CW'(1);
  assign push_ok  = cmd.start && (in_kind == fpsa_pkg::KIND_FREE) && !bad_free && !full;
  assign pop_ok   = cmd.start && (in_kind == fpsa_pkg::KIND_ALLOC) && !empty;

  always_comb begin
    case (in_kind)
      fpsa_pkg::KIND_FREE:  new_status = bad_free ? fpsa_pkg::STS_BAD :
                                         (full ? fpsa_pkg::STS_OVF : fpsa_pkg::STS_OK);
      fpsa_pkg::KIND_ALLOC: new_status = empty ? fpsa_pkg::STS_EMPTY : fpsa_pkg::STS_OK;
      fpsa_pkg::KIND_INIT:  new_status = n_sat ? fpsa_pkg::STS_OVF : fpsa_pkg::STS_OK;
      default:              new_status = fpsa_pkg::STS_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.start) begin
      if (push_ok) begin
        count_r <= count_r + CW'(1);
      end else if (pop_ok) begin
        count_r <= cnt_m1;
      end else if (in_kind == fpsa_pkg::KIND_INIT) begin
        count_r <= n_pages;
      end
    end
  end

  // init sweep: one ascending page per cycle from index zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_left_r <= '0;
    end else if (cmd.start && (in_kind == fpsa_pkg::KIND_INIT)) begin
      fill_left_r <= n_pages;
    end else if (cmd.fill_step && (fill_left_r != '0)) begin
      fill_left_r <= fill_left_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      fill_pg_r  <= PW'(first_pg);
      fill_idx_r <= '0;
    end else if (cmd.fill_step) begin
      fill_pg_r  <= fill_pg_r + PW'(1);
      fill_idx_r <= fill_idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      res_status_r  <= new_status;
      res_use_ram_r <= pop_ok;
    end
  end

  assign ram_we    = push_ok || (cmd.fill_step && (fill_left_r != '0));
  assign ram_waddr = push_ok ? count_r[IW-1:0] : fill_idx_r;
  assign ram_wdata = push_ok ? in_page_addr[AW-1:PB] : fill_pg_r;
  assign ram_re    = pop_ok;
  assign ram_raddr = cnt_m1[IW-1:0];

  fpsa_ram #(
    .W (PW),
    .D (fpsa_pkg::MAX_PAGES)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_addr_r   <= res_use_ram_r ? {ram_rdata, PB'(0)} : '0;
      out_status_r <= res_status_r;
      out_count_r  <= fpsa_pkg::FC_W'(count_r);
    end
  end

  assign sts.init_req  = in_kind == fpsa_pkg::KIND_INIT;
  assign sts.fill_done = fill_left_r == '0;
  assign sts.out_busy  = out_valid_r && !out_chan.ready;

  assign out_chan.valid      = out_valid_r;
  assign out_chan.alloc_addr = out_addr_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.free_count = out_count_r;

endmodule

>>> rtl/core/free_page_stack_allocator_top.sv
// Top level of the free page stack allocator: LIFO of free page numbers in one RAM.
// Free, alloc and unused kinds: after accept the controller goes to the hand-off state and loads
// the result word; the registered stack RAM read lands before that hand-off.
// Init of n pages: the fill sweep writes one stack entry per cycle before the hand-off state.
// The block takes no new word until the last result is handed off. A stalled sink holds the hand-off.
// Reset (rst_n, synchronous): empty stack, both region registers zero, no clearing pass.
module free_page_stack_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  fpsa_in_if.sink     in_chan,
  fpsa_out_if.source  out_chan,
  fpsa_cfg_if.sink    cfg_chan
);

  fpsa_pkg::ctrl_cmd_t cmd;
  fpsa_pkg::dp_sts_t   sts;
  logic                in_ready;

  // Controller: take one word at a time, walk the init sweep, then wait for the output
  // register to free up before handing over the result.
  fpsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_chan.ready = in_ready;

  // Datapath: checks the free address, pushes, pops or init-fills the stack, and holds the result
  // in the output register so a stalled sink never loses a word.
  fpsa_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_kind      (in_chan.kind),
    .in_page_addr (in_chan.page_addr),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_chan     (cfg_chan),
    .out_chan     (out_chan)
  );

endmodule

>>> rtl/core/fpsa_checker.sv
// Port-level checker for the free page stack allocator, bound to the top level
`include "free_page_stack_allocator_top_assert.svh"

module fpsa_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [fpsa_pkg::ADDR_W-1:0]  alloc_addr,
  input logic [1:0]                   status,
  input logic [fpsa_pkg::FC_W-1:0]    free_count
);

  `FPSA_CHK_ALL(a_reset_clears_out, !rst_n |=> !out_valid, "result word valid after reset")
  `FPSA_CHK_ALL(a_one_at_a_time, rst_n && in_valid && in_ready |=> !in_ready, "second word taken while busy")
  `FPSA_CHK(a_addr_only_on_ok, out_valid && (alloc_addr != '0) |-> status == fpsa_pkg::STS_OK, "page address with error status")
  `FPSA_CHK(a_addr_aligned, out_valid |-> alloc_addr[fpsa_pkg::PAGE_BITS-1:0] == '0, "allocated address not page aligned")
  `FPSA_CHK_ALL(a_out_hold, rst_n && out_valid && !out_ready |=> out_valid && $stable(alloc_addr) && $stable(status) && $stable(free_count), "stalled result word changed")

endmodule

bind free_page_stack_allocator_top fpsa_checker u_fpsa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .alloc_addr (out_chan.alloc_addr),
  .status     (out_chan.status),
  .free_count (out_chan.free_count)
);

>>> verif/fpsa_free_stack_checker.sv
// Checker for the free page stack allocator: predicts every result word and compares it
module fpsa_free_stack_checker
  import fpsa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  fpsa_in_if   in_mon,
  fpsa_out_if  out_mon,
  fpsa_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending_words,
  output int   words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'((1 << PAGE_BITS) - 1);

  typedef struct packed {
    logic [ADDR_W-1:0] alloc_addr;
    logic [1:0]        status;
    logic [FC_W-1:0]   free_count;
  } result_word_t;

  // Own copy of the region registers and the stack of free page numbers
  logic [ADDR_W-1:0] start_addr;
  logic [ADDR_W-1:0] end_addr;
  logic [PN_W-1:0]   page_stack [MAX_PAGES];
  int unsigned       depth;
  result_word_t      expected_q [$];
  int                fails = 0;
  int                checked = 0;

  initial begin
    fail_count    = 0;
    pending_words = 0;
    words_checked = 0;
  end

  // Apply one request to the predicted stack and return the word it should produce
  function automatic result_word_t stack_outcome(input logic [1:0] kind,
                                                 input logic [ADDR_W-1:0] addr);
    result_word_t r;
    logic [FIRST_W-1:0] first_pn;
    logic [FIRST_W-1:0] limit_pn;
    int unsigned n_pages;
    int unsigned i;
    r = '0;
    r.status = STS_OK;
    case (kind)
      KIND_FREE: begin
        if ((addr & PAGE_MASK) != '0 || addr < start_addr || addr >= end_addr) begin
          r.status = STS_BAD;
        end else if (depth >= MAX_PAGES) begin
          r.status = STS_OVF;
        end else begin
          page_stack[depth] = addr[ADDR_W-1:PAGE_BITS];
          depth++;
        end
      end
      KIND_ALLOC: begin
        if (depth == 0) begin
          r.status = STS_EMPTY;
        end else begin
          depth--;
          r.alloc_addr = ADDR_W'(page_stack[depth]) << PAGE_BITS;
        end
      end
      KIND_INIT: begin
        // round the start up without wrapping past the top of the address space
        first_pn = FIRST_W'(({1'b0, start_addr} + (33'd1 << PAGE_BITS) - 33'd1) >> PAGE_BITS);
        limit_pn = FIRST_W'(end_addr >> PAGE_BITS);
        n_pages  = (limit_pn > first_pn) ? int'(limit_pn - first_pn) : 0;
        if (n_pages > MAX_PAGES) begin
          n_pages  = MAX_PAGES;
          r.status = STS_OVF;
        end
        for (i = 0; i < n_pages; i++) page_stack[i] = PN_W'(first_pn + i);
        depth = n_pages;
      end
      default: ;
    endcase
    r.free_count = FC_W'(depth);
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    result_word_t got;
    result_word_t want;
    if (!rst_n) begin
      start_addr = '0;
      end_addr   = '0;
      depth      = 0;
      expected_q.delete();
    end else begin
      // retire the result first, so a word accepted on the same edge cannot match it
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.alloc_addr, out_mon.status, out_mon.free_count};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got addr %h status %0d count %0d",
                   $time, got.alloc_addr, got.status, got.free_count);
          fails++;
        end else begin
          want = expected_q.pop_front();
          compare_field("alloc_addr", want.alloc_addr, got.alloc_addr);
          compare_field("status", ADDR_W'(want.status), ADDR_W'(got.status));
          compare_field("free_count", ADDR_W'(want.free_count), ADDR_W'(got.free_count));
          checked++;
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_REGION_START) start_addr = cfg_mon.data;
        else if (cfg_mon.index == REG_REGION_END) end_addr = cfg_mon.data;
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(stack_outcome(in_mon.kind, in_mon.page_addr));
    end
    fail_count    <= fails;
    pending_words <= expected_q.size();
    words_checked <= checked;
  end

endmodule

>>> verif/free_page_stack_allocator_top_tb.sv
// Testbench top for the free page stack allocator: clock, reset, stimulus and verdict
module free_page_stack_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpsa_pkg::*;

  // Kind 3 has no meaning in the block; it must be ignored
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int PAGE_SIZE = 1 << PAGE_BITS;
  localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_SIZE - 1);
  // A full-stack init moves no word on any channel while the fill sweep runs; the limit allows for it
  localparam int QUIET_LIMIT = 5 * (MAX_PAGES + 3) + 1000;
  localparam int N_PHASES = 8;
  localparam int WORDS_PER_PHASE = 130;

  logic clk;
  logic rst_n;
  logic recv_ready = 1'b0;

  int unsigned send_gap_pct = 0;    // chance per cycle that the sender holds off
  int unsigned recv_stall_pct = 0;  // chance per cycle that the receiver stalls
  int fails;
  int pending;
  int checked;
  int quiet_cycles = 0;
  int sent_by_kind [4] = '{0, 0, 0, 0};
  int n_settings = 0;

  // Region currently programmed, mirrored here to aim the free addresses
  logic [ADDR_W-1:0] region_lo = '0;
  logic [ADDR_W-1:0] region_hi = '0;

  fpsa_in_if  req_if ();
  fpsa_out_if rsp_if ();
  fpsa_cfg_if cfg_if ();

  assign rsp_if.ready = recv_ready;

  free_page_stack_allocator_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (rsp_if),
    .cfg_chan (cfg_if)
  );

  fpsa_free_stack_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (req_if),
    .out_mon       (rsp_if),
    .cfg_mon       (cfg_if),
    .fail_count    (fails),
    .pending_words (pending),
    .words_checked (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: take every word, or stall at random when the phase asks for it
  always @(posedge clk) begin
    recv_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: give up when no word moves on any channel for too long
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one request word and hold it until the block takes it.
  // Valid stays high afterwards so back-to-back words need no extra edge.
  task automatic send_word(input logic [1:0] kind, input logic [ADDR_W-1:0] addr);
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_gap_pct) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.kind      <= kind;
    req_if.page_addr <= addr;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sent_by_kind[kind]++;
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Present one register write and hold it until taken; the caller drops valid
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  // Program both region bounds; only call with the block drained
  task automatic set_region(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
    write_reg(REG_REGION_START, lo);
    write_reg(REG_REGION_END, hi);
    cfg_if.valid <= 1'b0;
    region_lo = lo;
    region_hi = hi;
    n_settings++;
  endtask

  // A page-aligned address inside the region, or noise when the region holds no page
  function automatic logic [ADDR_W-1:0] valid_free_addr();
    logic [ADDR_W:0] lo_pn;
    logic [ADDR_W:0] hi_pn;
    lo_pn = ({1'b0, region_lo} + PAGE_SIZE - 1) >> PAGE_BITS;
    if (region_hi == '0) return $urandom;
    hi_pn = {1'b0, region_hi - 1'b1} >> PAGE_BITS;
    if (lo_pn > hi_pn) return $urandom;
    return ADDR_W'($urandom_range(int'(hi_pn), int'(lo_pn)) << PAGE_BITS);
  endfunction

  // A free address that should be refused: noise, misaligned, past the end or below the start
  function automatic logic [ADDR_W-1:0] bad_free_addr();
    case ($urandom_range(3))
      0: return $urandom;
      1: return valid_free_addr() | ADDR_W'($urandom_range(PAGE_SIZE - 1, 1));
      2: return (region_hi + ADDR_W'(PAGE_SIZE - 1)) & ~PAGE_MASK;
      default: return (region_lo - 1'b1) & ~PAGE_MASK;
    endcase
  endfunction

  // Choose the region for a random phase; most are a few dozen pages
  task automatic pick_region(input int ph);
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] base;
    base = $urandom & 32'h7FFF_F000;
    case (ph)
      // far more pages than the stack holds: init saturates, frees hit a full stack
      2: begin
        lo = base;
        hi = '1;
      end
      // any pair of bounds, often reversed or huge
      5: begin
        lo = $urandom;
        hi = $urandom;
      end
      // region from address zero
      6: begin
        lo = '0;
        hi = ADDR_W'($urandom_range(64, 1) << PAGE_BITS);
      end
      default: begin
        lo = base | ($urandom_range(1) ? ADDR_W'($urandom_range(PAGE_SIZE - 1)) : '0);
        hi = base + ADDR_W'($urandom_range(64, 2) << PAGE_BITS) +
             ADDR_W'($urandom_range(PAGE_SIZE - 1));
      end
    endcase
    set_region(lo, hi);
  endtask

  // Mostly allocs and good frees against an initialised stack, plus refused frees and noise
  task automatic send_random_word();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) send_word(KIND_INIT, $urandom);
    else if (roll < 5) send_word(KIND_UNUSED, $urandom);
    else if (roll < 45) send_word(KIND_ALLOC, $urandom);
    else if (roll < 85) send_word(KIND_FREE, valid_free_addr());
    else send_word(KIND_FREE, bad_free_addr());
  endtask

  initial begin
    // Hold every input at a known value while reset is held low
    rst_n            <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.kind      <= KIND_FREE;
    req_if.page_addr <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= REG_REGION_START;
    cfg_if.data      <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words, no idling. Both bounds are still zero after reset.
    send_word(KIND_ALLOC, '0);        // alloc on an empty stack
    send_word(KIND_UNUSED, '1);       // unused kind: ignore it
    send_word(KIND_INIT, '0);         // empty region leaves the stack empty
    send_word(KIND_FREE, '0);         // at or above the end of an empty region

    // Misaligned start: pages 4 to 8 are whole, page 9 is only partly inside
    drain_results();
    set_region(32'h0000_3001, 32'h0000_9800);
    send_word(KIND_INIT, $urandom);
    send_word(KIND_FREE, 32'h0000_3000);  // below the unrounded start
    send_word(KIND_FREE, 32'h0000_4004);  // misaligned
    send_word(KIND_FREE, 32'h0000_4000);  // double free goes unnoticed
    send_word(KIND_FREE, 32'h0000_9000);  // aligned and below the end, so accepted
    send_word(KIND_FREE, 32'h0000_A000);  // past the end
    // pop everything, then once more on the empty stack
    repeat (8) send_word(KIND_ALLOC, $urandom);

    // Start at the very top: rounding up must not wrap, so nothing is pushed
    drain_results();
    set_region('1, '1);
    send_word(KIND_INIT, '0);
    send_word(KIND_FREE, 32'hFFFF_F000);

    // Whole address space: init saturates, a free on the full stack overflows
    drain_results();
    set_region('0, '1);
    send_word(KIND_INIT, '0);
    send_word(KIND_FREE, 32'hFFFF_F000);
    send_word(KIND_ALLOC, '1);
    send_word(KIND_FREE, 32'hFFFF_F000);
    send_word(KIND_ALLOC, '0);

    // Random phases: each starts on a fresh region with an init, then mixed traffic.
    // Cycle through the idling mixes so gaps land on every step of the block's work.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      pick_region(ph);
      case (ph % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 50; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 50; end
        default: begin send_gap_pct = 12; recv_stall_pct = 12; end
      endcase
      send_word(KIND_INIT, $urandom);
      for (int i = 1; i < WORDS_PER_PHASE; i++) begin
        // once in the run, pause the sender mid-phase until the block runs dry
        if (ph == 3 && i == WORDS_PER_PHASE / 2) drain_results();
        send_random_word();
      end
    end

    // Let the last results come back, then idle for anything stray
    drain_results();
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);

    $display("Sent %0d words: %0d free, %0d alloc, %0d init, %0d of the unused kind",
             sent_by_kind[0] + sent_by_kind[1] + sent_by_kind[2] + sent_by_kind[3],
             sent_by_kind[KIND_FREE], sent_by_kind[KIND_ALLOC], sent_by_kind[KIND_INIT],
             sent_by_kind[KIND_UNUSED]);
    $display("Regions programmed: %0d, four idling mixes, results compared: %0d",
             n_settings, checked);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> free_page_stack_allocator_top.f
+incdir+rtl/core
rtl/core/fpsa_pkg.sv
rtl/core/fpsa_ifs.sv
rtl/core/fpsa_ram.sv
rtl/core/fpsa_ctrl.sv
rtl/core/fpsa_dp.sv
rtl/core/free_page_stack_allocator_top.sv
rtl/core/fpsa_checker.sv
verif/fpsa_free_stack_checker.sv
verif/free_page_stack_allocator_top_tb.sv
